/* rtl/sprite_frame_sequencer_defines.svh */
// Assertion macros shared by the sprite frame sequencer RTL.
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sfs_pkg.sv */
// Package of widths, codes and divider interface types for the sprite frame sequencer.
package sfs_pkg;

  localparam int PeriodW     = 16;
  localparam int ModeW       = 3;
  localparam int OriginW     = 4;
  localparam int ColsW       = 7;
  localparam int CountW      = 11;
  localparam int SizeW       = 13;
  localparam int PosW        = 10;
  localparam int RectXW      = 18;
  localparam int RectYW      = 22;
  localparam int OriginHalfW = 14;
  localparam int ElapsedW    = 32;
  localparam int DeltaW      = 16;
  localparam int CfgIndexW   = 3;
  localparam int CfgDataW    = 16;
  localparam int ProdW       = PosW + SizeW;

  localparam int DivW          = 33;
  localparam int DivisorW      = 16;
  localparam int DivLongSteps  = 33;
  localparam int DivShortSteps = 12;
  localparam int DivCntW       = $clog2(DivLongSteps + 1);

  localparam int MaxFramesDef  = 1024;
  localparam int MaxColumnsDef = 64;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PERIOD,
    REG_PLAY_MODE,
    REG_ORIGIN_MODE,
    REG_COLUMNS,
    REG_COUNT,
    REG_WIDTH,
    REG_HEIGHT,
    REG_ENABLE
  } cfg_reg_e;

  localparam logic [ModeW-1:0] MODE_LOOP_FWD  = 3'd0;
  localparam logic [ModeW-1:0] MODE_LOOP_BACK = 3'd1;
  localparam logic [ModeW-1:0] MODE_ONCE_FWD  = 3'd2;
  localparam logic [ModeW-1:0] MODE_ONCE_BACK = 3'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PLAY = 1'b1;

  localparam logic [PeriodW-1:0] RST_PERIOD  = 16'd100;
  localparam logic [ModeW-1:0]   RST_MODE    = MODE_LOOP_FWD;
  localparam logic [OriginW-1:0] RST_ORIGIN  = 4'd0;
  localparam logic [ColsW-1:0]   RST_COLUMNS = 7'd1;
  localparam logic [CountW-1:0]  RST_COUNT   = 11'd1;
  localparam logic [SizeW-1:0]   RST_WIDTH   = 13'd16;
  localparam logic [SizeW-1:0]   RST_HEIGHT  = 13'd16;
  localparam logic               RST_ENABLE  = 1'b1;

  typedef struct packed {
    logic                start;
    logic                short_op;
    logic [DivW-1:0]     dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivW-1:0]     quo;
    logic [DivisorW-1:0] rem;
  } div_rsp_t;

endpackage

/* rtl/sfs_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, long or short operand.
module sfs_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfs_pkg::div_req_t req_i,
  output sfs_pkg::div_rsp_t rsp_o
);
  import sfs_pkg::*;

  logic [DivW-1:0]     quo_q, quo_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] dvs_q, dvs_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;
  logic                fits;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // short operands sit at the top so only the short step count is needed
      quo_d = req_i.short_op ? (req_i.dividend << (DivW - DivShortSteps)) : req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = req_i.short_op ? DivCntW'(DivShortSteps) : DivCntW'(DivLongSteps);
    end else if (cnt_q != '0) begin
      quo_d  = {quo_q[DivW-2:0], fits};
      rem_d  = fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      cnt_d  = cnt_q - DivCntW'(1);
      done_d = (cnt_q == DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* rtl/sprite_frame_sequencer.sv */
// Sprite-sheet frame sequencer top level: config, sequencer, shared divider and multiplier.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in       | in_valid_i/in_stall_o   | operation_i, delta_ms_i, hold_i
//  out      | out_valid_o/out_stall_i | frame_index_o, rect_*_o, origin_*_o, playing_o
//
// One item at a time through a shared restoring divider (33 or 12 steps) and one multiplier.
// Without a frame advance only the row/column split uses the divider; an advance first divides
// elapsed by period; loop forward and loop back wrap add modulo passes before the row/column split.
// Async active-low reset; config regs take their defaults, state clears.
// A stalled result is held in the output register while the next beat may be accepted.
`include "sprite_frame_sequencer_defines.svh"

module sprite_frame_sequencer #(
  parameter int MAX_FRAMES  = sfs_pkg::MaxFramesDef,
  parameter int MAX_COLUMNS = sfs_pkg::MaxColumnsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sfs_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [sfs_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic [sfs_pkg::DeltaW-1:0]       delta_ms_i,
  input  logic                             hold_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sfs_pkg::PosW-1:0]         frame_index_o,
  output logic [sfs_pkg::RectXW-1:0]       rect_x_o,
  output logic [sfs_pkg::RectYW-1:0]       rect_y_o,
  output logic [sfs_pkg::OriginHalfW-1:0]  origin_x_halves_o,
  output logic [sfs_pkg::OriginHalfW-1:0]  origin_y_halves_o,
  output logic                             playing_o
);
  import sfs_pkg::*;

  localparam logic [CountW-1:0] FramesCap =
    (MAX_FRAMES > 2047) ? {CountW{1'b1}} : CountW'(MAX_FRAMES);
  localparam logic [ColsW-1:0] ColsCap =
    (MAX_COLUMNS > 127) ? {ColsW{1'b1}} : ColsW'(MAX_COLUMNS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_K,
    ST_DIV_P,
    ST_DIV_KM,
    ST_DIV_W,
    ST_SPLIT,
    ST_DIV_S,
    ST_MUL_X,
    ST_MUL_Y,
    ST_OUT
  } state_e;

  // configuration registers
  logic [PeriodW-1:0] frame_period_q;
  logic [ModeW-1:0]   play_mode_q;
  logic [OriginW-1:0] origin_mode_q;
  logic [ColsW-1:0]   sheet_columns_q;
  logic [CountW-1:0]  frame_count_q;
  logic [SizeW-1:0]   frame_width_q;
  logic [SizeW-1:0]   frame_height_q;
  logic               enable_q;

  state_e                 state_q, state_d;
  logic [ElapsedW-1:0]    elapsed_q, elapsed_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic                   running_q, running_d;
  logic [ColsW-1:0]       col_q, col_d;
  logic [PosW-1:0]        row_q, row_d;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic [RectXW-1:0]      x_q, x_d;
  logic                   out_valid_q, out_valid_d;
  logic [PosW-1:0]        frame_index_q, frame_index_d;
  logic [RectXW-1:0]      rect_x_q, rect_x_d;
  logic [RectYW-1:0]      rect_y_q, rect_y_d;
  logic [OriginHalfW-1:0] ox_q, ox_d;
  logic [OriginHalfW-1:0] oy_q, oy_d;
  logic                   playing_q, playing_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                   in_accept;
  logic                   out_free;
  logic                   div_wait;
  logic [ElapsedW:0]      sum;
  logic [ElapsedW-1:0]    sat;
  logic [PeriodW-1:0]     period_eff;
  logic                   adv_due;
  logic                   adv_mode;
  logic                   back_mode;
  logic [CountW-1:0]      n_eff;
  logic [CountW-1:0]      n_m1;
  logic [ColsW-1:0]       cols_eff;
  logic [DivW-1:0]        fwd_sum;
  logic                   fwd_over;
  logic [PosW-1:0]        back_diff;
  logic                   back_out;
  logic [CountW:0]        wrap_sum;
  logic [PosW-1:0]        mul_a;
  logic [SizeW-1:0]       mul_b;
  logic [ProdW-1:0]       mul_p;
  logic [1:0]             org_col;
  logic [1:0]             org_row;
  logic [OriginHalfW-1:0] ox_val;
  logic [OriginHalfW-1:0] oy_val;

  sfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign div_wait    = (state_q == ST_DIV_K) || (state_q == ST_DIV_P) ||
                       (state_q == ST_DIV_KM) || (state_q == ST_DIV_W) ||
                       (state_q == ST_DIV_S);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_period_q  <= RST_PERIOD;
      play_mode_q     <= RST_MODE;
      origin_mode_q   <= RST_ORIGIN;
      sheet_columns_q <= RST_COLUMNS;
      frame_count_q   <= RST_COUNT;
      frame_width_q   <= RST_WIDTH;
      frame_height_q  <= RST_HEIGHT;
      enable_q        <= RST_ENABLE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PERIOD:      frame_period_q  <= cfg_data_i[PeriodW-1:0];
        REG_PLAY_MODE:   play_mode_q     <= cfg_data_i[ModeW-1:0];
        REG_ORIGIN_MODE: origin_mode_q   <= cfg_data_i[OriginW-1:0];
        REG_COLUMNS:     sheet_columns_q <= cfg_data_i[ColsW-1:0];
        REG_COUNT:       frame_count_q   <= cfg_data_i[CountW-1:0];
        REG_WIDTH:       frame_width_q   <= cfg_data_i[SizeW-1:0];
        REG_HEIGHT:      frame_height_q  <= cfg_data_i[SizeW-1:0];
        REG_ENABLE:      enable_q        <= cfg_data_i[0];
        default:         enable_q        <= enable_q;
      endcase
    end
  end

  // effective settings
  assign period_eff = (frame_period_q == '0) ? PeriodW'(1) : frame_period_q;
  assign n_eff      = (frame_count_q == '0) ? CountW'(1) :
                      (frame_count_q > FramesCap) ? FramesCap : frame_count_q;
  assign n_m1       = n_eff - CountW'(1);
  assign cols_eff   = (sheet_columns_q == '0) ? ColsW'(1) :
                      (sheet_columns_q > ColsCap) ? ColsCap : sheet_columns_q;
  assign adv_mode   = (play_mode_q == MODE_LOOP_FWD) || (play_mode_q == MODE_LOOP_BACK) ||
                      (play_mode_q == MODE_ONCE_FWD) || (play_mode_q == MODE_ONCE_BACK);
  assign back_mode  = (play_mode_q == MODE_LOOP_BACK) || (play_mode_q == MODE_ONCE_BACK);

  // saturating time accumulation
  assign sum     = {1'b0, elapsed_q} + {{(ElapsedW + 1 - DeltaW){1'b0}}, delta_ms_i};
  assign sat     = sum[ElapsedW] ? {ElapsedW{1'b1}} : sum[ElapsedW-1:0];
  assign adv_due = !hold_i && (sat >= {{(ElapsedW - PeriodW){1'b0}}, period_eff});

  // advance arithmetic on the frame step count from the divider
  assign fwd_sum   = {{(DivW - PosW){1'b0}}, pos_q} + div_rsp.quo;
  assign fwd_over  = fwd_sum >= {{(DivW - CountW){1'b0}}, n_eff};
  assign back_diff = pos_q - div_rsp.quo[PosW-1:0];
  assign back_out  = (div_rsp.quo > {{(DivW - PosW){1'b0}}, pos_q}) ||
                     ({{(CountW - PosW){1'b0}}, back_diff} >= n_eff);
  assign wrap_sum  = {{(CountW + 1 - PosW){1'b0}}, pos_q} + {1'b0, n_eff}
                   - {1'b0, div_rsp.rem[CountW-1:0]};

  // shared multiplier, operands picked by state
  assign mul_a = (state_q == ST_MUL_X) ? {{(PosW - ColsW){1'b0}}, col_q} : row_q;
  assign mul_b = (state_q == ST_MUL_X) ? frame_width_q : frame_height_q;
  assign mul_p = mul_a * mul_b;

  // anchor: for modes 0 to 8 column is mode mod 3, row is mode div 3; other modes use column 0, row 0
  always_comb begin
    org_col = 2'd0;
    org_row = 2'd0;
    unique case (origin_mode_q)
      4'd0: begin org_col = 2'd0; org_row = 2'd0; end
      4'd1: begin org_col = 2'd1; org_row = 2'd0; end
      4'd2: begin org_col = 2'd2; org_row = 2'd0; end
      4'd3: begin org_col = 2'd0; org_row = 2'd1; end
      4'd4: begin org_col = 2'd1; org_row = 2'd1; end
      4'd5: begin org_col = 2'd2; org_row = 2'd1; end
      4'd6: begin org_col = 2'd0; org_row = 2'd2; end
      4'd7: begin org_col = 2'd1; org_row = 2'd2; end
      4'd8: begin org_col = 2'd2; org_row = 2'd2; end
      default: begin org_col = 2'd0; org_row = 2'd0; end
    endcase
  end

  assign ox_val = (org_col == 2'd2) ? {frame_width_q, 1'b0} :
                  (org_col == 2'd1) ? {1'b0, frame_width_q} : '0;
  assign oy_val = (org_row == 2'd2) ? {frame_height_q, 1'b0} :
                  (org_row == 2'd1) ? {1'b0, frame_height_q} : '0;

  always_comb begin
    state_d       = state_q;
    elapsed_d     = elapsed_q;
    pos_d         = pos_q;
    running_d     = running_q;
    col_d         = col_q;
    row_d         = row_q;
    prod_d        = prod_q;
    x_d           = x_q;
    frame_index_d = frame_index_q;
    rect_x_d      = rect_x_q;
    rect_y_d      = rect_y_q;
    ox_d          = ox_q;
    oy_d          = oy_q;
    playing_d     = playing_q;
    out_valid_d   = out_valid_q && out_stall_i;
    div_req       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SPLIT;
          if (enable_q) begin
            if (operation_i == OP_PLAY) begin
              running_d = 1'b1;
              elapsed_d = '0;
              pos_d     = back_mode ? n_m1[PosW-1:0] : '0;
            end else if (adv_due) begin
              elapsed_d = '0;
              if (running_q && adv_mode) begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, sat};
                div_req.divisor  = period_eff;
                state_d          = ST_DIV_K;
              end
            end else begin
              elapsed_d = sat;
            end
          end
        end
      end

      ST_DIV_K: begin
        if (div_rsp.done) begin
          state_d = ST_SPLIT;
          unique case (play_mode_q)
            MODE_LOOP_FWD: begin
              div_req.start    = 1'b1;
              div_req.dividend = fwd_sum;
              div_req.divisor  = {{(DivisorW - CountW){1'b0}}, n_eff};
              state_d          = ST_DIV_P;
            end
            MODE_ONCE_FWD: begin
              if (fwd_over) begin
                pos_d     = n_m1[PosW-1:0];
                running_d = 1'b0;
              end else begin
                pos_d = fwd_sum[PosW-1:0];
              end
            end
            MODE_LOOP_BACK: begin
              if (back_out) begin
                div_req.start    = 1'b1;
                div_req.dividend = div_rsp.quo;
                div_req.divisor  = {{(DivisorW - CountW){1'b0}}, n_eff};
                state_d          = ST_DIV_KM;
              end else begin
                pos_d = back_diff;
              end
            end
            MODE_ONCE_BACK: begin
              if (back_out) begin
                pos_d     = '0;
                running_d = 1'b0;
              end else begin
                pos_d = back_diff;
              end
            end
            default: pos_d = pos_q;
          endcase
        end
      end

      ST_DIV_P: begin
        if (div_rsp.done) begin
          pos_d   = div_rsp.rem[PosW-1:0];
          state_d = ST_SPLIT;
        end
      end

      ST_DIV_KM: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.short_op = 1'b1;
          div_req.dividend = {{(DivW - CountW - 1){1'b0}}, wrap_sum};
          div_req.divisor  = {{(DivisorW - CountW){1'b0}}, n_eff};
          state_d          = ST_DIV_W;
        end
      end

      ST_DIV_W: begin
        if (div_rsp.done) begin
          pos_d   = div_rsp.rem[PosW-1:0];
          state_d = ST_SPLIT;
        end
      end

      ST_SPLIT: begin
        div_req.start    = 1'b1;
        div_req.short_op = 1'b1;
        div_req.dividend = {{(DivW - PosW){1'b0}}, pos_q};
        div_req.divisor  = {{(DivisorW - ColsW){1'b0}}, cols_eff};
        state_d          = ST_DIV_S;
      end

      ST_DIV_S: begin
        if (div_rsp.done) begin
          col_d   = div_rsp.rem[ColsW-1:0];
          row_d   = div_rsp.quo[PosW-1:0];
          state_d = ST_MUL_X;
        end
      end

      ST_MUL_X: begin
        prod_d  = mul_p;
        state_d = ST_MUL_Y;
      end

      ST_MUL_Y: begin
        x_d     = prod_q[RectXW-1:0];
        prod_d  = mul_p;
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (out_free) begin
          frame_index_d = pos_q;
          rect_x_d      = x_q;
          rect_y_d      = prod_q[RectYW-1:0];
          ox_d          = ox_val;
          oy_d          = oy_val;
          playing_d     = running_q;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      elapsed_q     <= '0;
      pos_q         <= '0;
      running_q     <= 1'b0;
      col_q         <= '0;
      row_q         <= '0;
      prod_q        <= '0;
      x_q           <= '0;
      out_valid_q   <= 1'b0;
      frame_index_q <= '0;
      rect_x_q      <= '0;
      rect_y_q      <= '0;
      ox_q          <= '0;
      oy_q          <= '0;
      playing_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      elapsed_q     <= elapsed_d;
      pos_q         <= pos_d;
      running_q     <= running_d;
      col_q         <= col_d;
      row_q         <= row_d;
      prod_q        <= prod_d;
      x_q           <= x_d;
      out_valid_q   <= out_valid_d;
      frame_index_q <= frame_index_d;
      rect_x_q      <= rect_x_d;
      rect_y_q      <= rect_y_d;
      ox_q          <= ox_d;
      oy_q          <= oy_d;
      playing_q     <= playing_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_index_o     = frame_index_q;
  assign rect_x_o          = rect_x_q;
  assign rect_y_o          = rect_y_q;
  assign origin_x_halves_o = ox_q;
  assign origin_y_halves_o = oy_q;
  assign playing_o         = playing_q;

  `SFS_ASSERT_NOW(a_div_done_waited, div_rsp.done, div_wait, "divider result with no state waiting")
  `SFS_ASSERT_NEXT(a_play_restarts, in_accept && enable_q && operation_i == OP_PLAY, running_q && elapsed_q == '0, "play beat did not restart the animation")
  `SFS_ASSERT_NOW(a_new_result_from_out, out_valid_o && !$past(out_valid_o), $past(state_q == ST_OUT), "result appeared outside the output step")

endmodule
